[rtl/cro_pkg.sv]
// Shared types and constants for the color replace / ordered dither block.
// Holds the configuration register set, register index codes and the 8x8 threshold table.
// No dependencies.
package cro_pkg;

  typedef enum logic [2:0] {
    REG_MONO_MODE    = 3'd0,
    REG_KEY_COLOR    = 3'd1,
    REG_TARGET_RED   = 3'd2,
    REG_TARGET_GREEN = 3'd3,
    REG_TARGET_BLUE  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic       mono_mode;
    logic [7:0] key_color;
    logic [7:0] target_red;
    logic [7:0] target_green;
    logic [7:0] target_blue;
  } cfg_t;

  // threshold table, indexed by {column_phase, row_phase}
  localparam logic [5:0] BAYER8 [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

endpackage

[rtl/cro_cfg_regs.sv]
// Configuration register file for the color replace / ordered dither block.
// Decodes register index writes into the cfg_t register set.
// Depends on cro_pkg.
module cro_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [7:0]          wr_data,
  output cro_pkg::cfg_t       cfg
);
  import cro_pkg::*;

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (wr_index)
        REG_MONO_MODE:    cfg_next.mono_mode    = wr_data[0];
        REG_KEY_COLOR:    cfg_next.key_color    = wr_data;
        REG_TARGET_RED:   cfg_next.target_red   = wr_data;
        REG_TARGET_GREEN: cfg_next.target_green = wr_data;
        REG_TARGET_BLUE:  cfg_next.target_blue  = wr_data;
        default:          cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

[rtl/cro_dither_core.sv]
// Per-pixel key match and ordered dither of the target color.
// Pure combinational datapath between the input and result registers.
// Depends on cro_pkg.
module cro_dither_core (
  input  cro_pkg::cfg_t cfg,
  input  logic [2:0]    column_phase,
  input  logic [2:0]    row_phase,
  input  logic [7:0]    pixel_in,
  output logic [7:0]    pixel_out,
  output logic          was_replaced
);
  import cro_pkg::*;

  // level = t/85, plus one when floor(64*(t%85)/85) > thr, i.e. 64*rem >= 85*(thr+1)
  function automatic logic [1:0] channel_level(input logic [7:0] t, input logic [5:0] thr);
    logic [1:0]  lvl;
    logic [6:0]  rem;
    logic [12:0] lhs;
    logic [12:0] rhs;
    if (t >= 8'd255) begin
      lvl = 2'd3;
      rem = 7'd0;
    end else if (t >= 8'd170) begin
      lvl = 2'd2;
      rem = 7'(t - 8'd170);
    end else if (t >= 8'd85) begin
      lvl = 2'd1;
      rem = 7'(t - 8'd85);
    end else begin
      lvl = 2'd0;
      rem = t[6:0];
    end
    lhs = {rem, 6'b0};
    rhs = 13'(({7'b0, thr} + 13'd1) * 13'd85);
    return lvl + {1'b0, (lhs >= rhs)};
  endfunction

  logic [5:0]  thr;
  logic [10:0] sum;
  logic [8:0]  rnd;
  logic [6:0]  inten;
  logic        mono_hit;
  logic        color_hit;

  assign thr       = BAYER8[{column_phase, row_phase}];
  assign sum       = 11'(cfg.target_red) * 11'd3 + {1'b0, cfg.target_green, 2'b0}
                   + 11'(cfg.target_blue);
  assign rnd       = {1'b0, sum[10:3]} + 9'd5;
  assign inten     = rnd[8:2] - 7'd1;
  assign mono_hit  = pixel_in[0] == cfg.key_color[0];
  assign color_hit = pixel_in == cfg.key_color;

  always_comb begin
    pixel_out    = pixel_in;
    was_replaced = 1'b0;
    if (cfg.mono_mode) begin
      if (mono_hit) begin
        pixel_out    = {pixel_in[7:1], (inten > {1'b0, thr})};
        was_replaced = 1'b1;
      end
    end else if (color_hit) begin
      pixel_out    = {2'b11, channel_level(cfg.target_red, thr),
                      channel_level(cfg.target_green, thr),
                      channel_level(cfg.target_blue, thr)};
      was_replaced = 1'b1;
    end
  end

endmodule

[rtl/color_replace_ordered_dither.sv]
// Top level of the color replace / ordered dither block.
// Input register, dither core and result register; depends on cro_pkg,
// cro_cfg_regs and cro_dither_core.
//
// Usage:
//   s_axis carries one pixel request per beat: tdata[2:0] column phase,
//   tdata[5:3] row phase, tdata[13:6] pixel value, tdata[15:14] zero.
//   m_axis returns one result per request: tdata[7:0] new pixel value,
//   tuser[0] set when the pixel matched the key color.
//   The cfg channel writes the five registers by index (0 mono mode,
//   1 key color, 2..4 target red, green, blue); cfg_ready is always high.
//   Write configuration only while no request is in flight.
// An accepted request is held in the input register, passes the dither core
//   and is captured in the result register once that register is free.
// Throughput: one request per cycle while the receiver takes results, set by
//   the two register stages; the input side keeps accepting while a result
//   waits as long as the input register is free.
// Reset clears both stage valid flags and the configuration registers to zero.
// When the receiver stalls the result holds; one more request fills the
//   input register, then s_axis_tready drops until the receiver takes data.
module color_replace_ordered_dither (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] column_phase, [5:3] row_phase, [13:6] pixel_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic [0:0]  m_axis_tuser,   // [0] was_replaced
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cro_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [2:0] in_col;
  logic [2:0] in_row;
  logic [7:0] in_pix;
  logic       out_valid;
  logic [7:0] out_pix;
  logic       out_hit;
  logic [7:0] core_pix;
  logic       core_hit;
  logic       out_load;
  logic       in_load;

  assign cfg_ready = 1'b1;

  cro_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cro_dither_core u_core (
    .cfg          (cfg),
    .column_phase (in_col),
    .row_phase    (in_row),
    .pixel_in     (in_pix),
    .pixel_out    (core_pix),
    .was_replaced (core_hit)
  );

  assign out_load      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_col <= s_axis_tdata[2:0];
      in_row <= s_axis_tdata[5:3];
      in_pix <= s_axis_tdata[13:6];
    end
    if (out_load && in_valid) begin
      out_pix <= core_pix;
      out_hit <= core_hit;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_pix;
  assign m_axis_tuser[0] = out_hit;

endmodule

[rtl/cro_checker.sv]
// Port-level checks for the color replace / ordered dither block.
// Watches the input and result stream ports; bound to the top level below.
// Depends on color_replace_ordered_dither.
module cro_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is free");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without a request two cycles earlier");

endmodule

bind color_replace_ordered_dither cro_checker u_cro_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
